[sv/ttr_pkg.sv]
// Shared types and constants of the tunnel texture renderer.
// Depends on nothing; all files but ttr_ram use it by scope.
package ttr_pkg;

   localparam int unsigned MapDepthDefault = 65536;
   localparam int unsigned SineDepth       = 256;
   localparam int unsigned TexDepth        = 65536;
   localparam int unsigned QueueDepth      = 4;
   localparam int unsigned MapAddrMaxW     = 16;

   typedef enum logic [1:0] {
      OP_SINE_WR = 2'd0,
      OP_MAP_WR  = 2'd1,
      OP_TEX_WR  = 2'd2,
      OP_RENDER  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      req_type;
      logic [15:0] table_index;
      logic [15:0] write_value;
      logic [15:0] frame_count;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  pixel_value;
      logic [15:0] pixel_index;
   } rsp_item_type;

   typedef struct packed {
      req_item_type           item;
      logic [MapAddrMaxW-1:0] map_addr;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } queue_push_type;

endpackage

[sv/ttr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for every table of the renderer.
module ttr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while the reader stalls
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ttr_front.sv]
// Front end: accepts items and reduces the pixel index modulo the map depth.
// Uses ttr_pkg types; feeds ttr_queue.
module ttr_front #(
   parameter int unsigned MAP_DEPTH = ttr_pkg::MapDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  ttr_pkg::req_item_type   req_data,
   input  logic                    q_full,
   output ttr_pkg::queue_push_type q_push
);

   // index mod MAP_DEPTH = index - floor(index * Recip / 2^32) * MAP_DEPTH, one fix-up
   localparam longint unsigned RecipVal = (64'd1 << 32) / MAP_DEPTH;
   localparam int unsigned RecipW = $clog2(RecipVal + 1);
   localparam int unsigned ProdW  = 16 + RecipW;
   localparam int unsigned QuotW  = ProdW - 32;
   localparam int unsigned DepthW = $clog2(MAP_DEPTH + 1);
   localparam int unsigned QdW    = QuotW + DepthW;
   localparam logic [RecipW-1:0] MapRecip = RecipW'(RecipVal);
   localparam logic [16:0] MapDepthW = 17'(MAP_DEPTH);

   logic                  f_adv;
   logic                  f1_valid_ff, f1_valid_in;
   logic                  f2_valid_ff;
   logic                  f3_valid_ff;
   ttr_pkg::req_item_type f1_item_ff, f2_item_ff, f3_item_ff;
   logic [ProdW-1:0]      f1_prod_ff, f1_prod_in;
   logic [16:0]           f2_qd_ff, f2_qd_in;
   logic [16:0]           f3_rem_ff, f3_rem_in;
   logic [16:0]           rem_fix;

   // the whole front stalls only when its last stage cannot enter the queue
   assign f_adv       = !(f3_valid_ff && q_full);
   assign req_full    = !f_adv;
   assign f1_valid_in = req_push && f_adv;

   assign f1_prod_in = ProdW'(req_data.table_index) * ProdW'(MapRecip);
   assign f2_qd_in   = 17'(QdW'(f1_prod_ff[ProdW-1:32]) * QdW'(MAP_DEPTH));
   assign f3_rem_in  = {1'b0, f2_item_ff.table_index} - f2_qd_ff;
   assign rem_fix    = (f3_rem_ff >= MapDepthW) ? f3_rem_ff - MapDepthW : f3_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (f_adv) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         f1_item_ff <= req_data;
         f1_prod_ff <= f1_prod_in;
         f2_item_ff <= f1_item_ff;
         f2_qd_ff   <= f2_qd_in;
         f3_item_ff <= f2_item_ff;
         f3_rem_ff  <= f3_rem_in;
      end
   end

   always_comb begin
      q_push.push           = f3_valid_ff && !q_full;
      q_push.entry.item     = f3_item_ff;
      q_push.entry.map_addr = ttr_pkg::MapAddrMaxW'(rem_fix);
   end

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      f3_valid_ff |-> (rem_fix < MapDepthW))
      else $error("map address reduction out of range");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (f3_valid_ff && q_full) |=> (f3_valid_ff && $stable(f3_rem_ff)))
      else $error("stalled front stage lost its item");

endmodule

[sv/ttr_queue.sv]
// Short queue between front and back ends of the renderer.
// Uses ttr_pkg entry types.
module ttr_queue #(
   parameter int unsigned DEPTH = ttr_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttr_pkg::queue_push_type  q_push,
   input  logic                     q_pop,
   output logic                     q_full,
   output logic                     q_empty,
   output ttr_pkg::queue_entry_type q_head
);

   localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0]   LastPtr   = PtrW'(DEPTH - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(DEPTH);

   ttr_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign q_full  = (count_ff == FullCount);
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("queue written while full");

endmodule

[sv/ttr_back.sv]
// Back end: runs table writes and the render lookup chain in order.
// Uses ttr_pkg types and four ttr_ram instances.
module ttr_back #(
   parameter int unsigned MAP_DEPTH = ttr_pkg::MapDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  ttr_pkg::queue_entry_type q_head,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output ttr_pkg::rsp_item_type    rsp_data
);

   localparam int unsigned AddrW = $clog2(MAP_DEPTH);
   localparam int unsigned SineW = $clog2(ttr_pkg::SineDepth);
   localparam int unsigned TexW  = $clog2(ttr_pkg::TexDepth);

   logic adv;

   logic sine_wr_en, map_wr_en, tex_wr_en;
   logic [15:0] sine_a_rd, sine_b_rd, map_rd;
   logic [7:0]  tex_rd;
   logic [TexW-1:0] tex_rd_addr;

   logic             b1_valid_ff, b2_valid_ff, b3_valid_ff, b3_valid_in;
   ttr_pkg::op_type  b1_op_ff, b2_op_ff;
   logic [15:0]      b1_index_ff, b2_index_ff, b3_index_ff;
   logic [7:0]       b1_value_ff, b2_value_ff;
   logic [15:0]      b1_frame_ff;
   logic [15:0]      b2_ofs_ff, ofs_in;
   logic [15:0]      b2_map_ff;

   logic signed [15:0] sin_c, sin_2c;
   logic [15:0]        u_val, v_val;

   assign adv   = !b3_valid_ff || rsp_pop;
   assign q_pop = adv && !q_empty;

   // sine and map writes take effect at the stage where those tables are read
   assign sine_wr_en = q_pop && (q_head.item.req_type == ttr_pkg::OP_SINE_WR);
   assign map_wr_en  = q_pop && (q_head.item.req_type == ttr_pkg::OP_MAP_WR);

   // two copies of the sine table give the two reads per pixel
   ttr_ram #(.WIDTH(16), .DEPTH(ttr_pkg::SineDepth)) u_sine_a (
      .clock   (clock),
      .wr_en   (sine_wr_en),
      .wr_addr (q_head.item.table_index[SineW-1:0]),
      .wr_data (q_head.item.write_value),
      .rd_en   (adv),
      .rd_addr (q_head.item.frame_count[SineW-1:0]),
      .rd_data (sine_a_rd)
   );

   ttr_ram #(.WIDTH(16), .DEPTH(ttr_pkg::SineDepth)) u_sine_b (
      .clock   (clock),
      .wr_en   (sine_wr_en),
      .wr_addr (q_head.item.table_index[SineW-1:0]),
      .wr_data (q_head.item.write_value),
      .rd_en   (adv),
      .rd_addr ({q_head.item.frame_count[SineW-2:0], 1'b0}),
      .rd_data (sine_b_rd)
   );

   ttr_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (q_head.map_addr[AddrW-1:0]),
      .wr_data (q_head.item.write_value),
      .rd_en   (adv),
      .rd_addr (q_head.map_addr[AddrW-1:0]),
      .rd_data (map_rd)
   );

   // scroll offset from frame count and the two sine samples
   always_comb begin
      sin_c  = $signed(sine_a_rd);
      sin_2c = $signed(sine_b_rd);
      u_val  = {b1_frame_ff[14:0], 1'b0} - 16'(sin_2c >>> 8) + 16'(sin_c >>> 9);
      v_val  = {b1_frame_ff[13:0], 2'b00} + 16'(sin_c >>> 10);
      ofs_in = {v_val[7:0], 8'h00} + u_val;
   end

   assign tex_rd_addr = b2_map_ff + b2_ofs_ff;
   assign tex_wr_en   = adv && b2_valid_ff && (b2_op_ff == ttr_pkg::OP_TEX_WR);

   ttr_ram #(.WIDTH(8), .DEPTH(ttr_pkg::TexDepth)) u_tex (
      .clock   (clock),
      .wr_en   (tex_wr_en),
      .wr_addr (b2_index_ff),
      .wr_data (b2_value_ff),
      .rd_en   (adv),
      .rd_addr (tex_rd_addr),
      .rd_data (tex_rd)
   );

   assign b3_valid_in = b2_valid_ff && (b2_op_ff == ttr_pkg::OP_RENDER);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= q_pop;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_op_ff    <= q_head.item.req_type;
         b1_index_ff <= q_head.item.table_index;
         b1_value_ff <= q_head.item.write_value[7:0];
         b1_frame_ff <= q_head.item.frame_count;
         b2_op_ff    <= b1_op_ff;
         b2_index_ff <= b1_index_ff;
         b2_value_ff <= b1_value_ff;
         b2_ofs_ff   <= ofs_in;
         b2_map_ff   <= map_rd;
         b3_index_ff <= b2_index_ff;
      end
   end

   assign rsp_empty            = !b3_valid_ff;
   assign rsp_data.pixel_value = tex_rd;
   assign rsp_data.pixel_index = b3_index_ff;

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv && b2_valid_ff && (b2_op_ff != ttr_pkg::OP_RENDER)) |=> !b3_valid_ff)
      else $error("write item produced a result");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (b3_valid_ff && !rsp_pop) |=> (b3_valid_ff && $stable(b3_index_ff)))
      else $error("waiting result changed before pop");

endmodule

[sv/tunnel_texture_renderer_top.sv]
// Top level of the tunnel texture renderer: front end, queue, back end.
// Depends on ttr_pkg, ttr_front, ttr_queue, ttr_back and ttr_ram.
//
//   channel   direction  handshake                 payload
//   req_      in         req_push / req_full       ttr_pkg::req_item_type
//   rsp_      out        rsp_pop / rsp_empty       ttr_pkg::rsp_item_type
//
// One item per clock sustained while results are popped: every item takes
// one slot in each stage through the texture lookup, and only render items
// go on to the result stage. A render result passes the front registers,
// a queue entry and the back registers in turn; write items leave no result.
// Reset clears pipeline valid bits, queue pointers and queue count only;
// table contents are undefined until loaded, so there is no clearing pass.
// A held result stalls the back end; the queue absorbs up to four items
// before req_full rises, and the front end keeps accepting meanwhile.
module tunnel_texture_renderer_top #(
   parameter int unsigned MAP_DEPTH = ttr_pkg::MapDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  ttr_pkg::req_item_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output ttr_pkg::rsp_item_type rsp_data
);

   ttr_pkg::queue_push_type  q_push;
   ttr_pkg::queue_entry_type q_head;
   logic                     q_full;
   logic                     q_empty;
   logic                     q_pop;

   // accept items and reduce the map address
   ttr_front #(.MAP_DEPTH(MAP_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   // decouple front and back stalls
   ttr_queue #(.DEPTH(ttr_pkg::QueueDepth)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_pop   (q_pop),
      .q_full  (q_full),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // run table writes and the render lookups in order
   ttr_back #(.MAP_DEPTH(MAP_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for tunnel_texture_renderer_top: loads the sine, map and texture
// tables, renders pixels and checks every rendered item against a shadow-table predictor.
// Depends on ttr_pkg and tunnel_texture_renderer_top.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned MapDepth   = ttr_pkg::MapDepthDefault;
   localparam int unsigned RandomOps  = 1375;
   localparam int unsigned DrainWait  = 32;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   ttr_pkg::req_item_type req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop  = 1'b0;
   ttr_pkg::rsp_item_type rsp_data;

   // Shadow copies of the three tables, with a loaded flag per entry so that no
   // render ever reads an entry the block has not been given.
   logic [15:0] sine_shadow [ttr_pkg::SineDepth];
   logic [15:0] map_shadow  [MapDepth];
   logic [7:0]  tex_shadow  [ttr_pkg::TexDepth];
   bit          sine_loaded [ttr_pkg::SineDepth];
   bit          map_loaded  [MapDepth];
   bit          tex_loaded  [ttr_pkg::TexDepth];

   // Rendered pixels still owed by the block, oldest first.
   ttr_pkg::rsp_item_type pixel_expect_q [$];

   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;
   bit          req_burst      = 1'b0;
   bit          rsp_burst      = 1'b0;
   bit          back_to_back   = 1'b0;

   tunnel_texture_renderer_top #(.MAP_DEPTH(MapDepth)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Hard stop: far beyond the slowest legal run (every item waiting out the
   // longest gap and the longest pop stall).
   initial begin
      #2_000_000;
      $display("tunnel_texture_renderer_top regression: fail");
      $finish;
   end

   // Draw a random wait, or none inside a burst stretch where nobody idles;
   // now and then flip into or out of such a stretch.
   function automatic int unsigned draw_wait(inout bit burst);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic int unsigned map_slot(logic [15:0] idx);
      return idx % MapDepth;
   endfunction

   // Texture address a render of pixel idx at frame c reads, from the shadow
   // tables as they stand now.
   function automatic logic [15:0] texel_addr(logic [15:0] c, logic [15:0] idx);
      int s1, s2, u, v, ofs;
      s1  = int'($signed(sine_shadow[c[7:0]]));
      s2  = int'($signed(sine_shadow[{c[6:0], 1'b0}]));
      u   = 2 * int'(c) - (s2 >>> 8) + (s1 >>> 9);
      v   = 4 * int'(c) + (s1 >>> 10);
      ofs = (v * 256 + u) & 'hFFFF;
      return 16'(int'(map_shadow[map_slot(idx)]) + ofs);
   endfunction

   // Apply one accepted item to the shadow tables; a render queues its pixel.
   function automatic void predict_texel(ttr_pkg::req_item_type it);
      ttr_pkg::rsp_item_type px;
      case (it.req_type)
         ttr_pkg::OP_SINE_WR: begin
            // only the low address byte selects the sine entry
            sine_shadow[it.table_index[7:0]] = it.write_value;
            sine_loaded[it.table_index[7:0]] = 1'b1;
         end
         ttr_pkg::OP_MAP_WR: begin
            map_shadow[map_slot(it.table_index)] = it.write_value;
            map_loaded[map_slot(it.table_index)] = 1'b1;
         end
         ttr_pkg::OP_TEX_WR: begin
            // the texture keeps the low data byte only
            tex_shadow[it.table_index] = it.write_value[7:0];
            tex_loaded[it.table_index] = 1'b1;
         end
         default: begin
            px.pixel_value = tex_shadow[texel_addr(it.frame_count, it.table_index)];
            px.pixel_index = it.table_index;
            pixel_expect_q.push_back(px);
         end
      endcase
   endfunction

   function automatic ttr_pkg::req_item_type make_item(ttr_pkg::op_type op,
                                                       logic [15:0] idx,
                                                       logic [15:0] val,
                                                       logic [15:0] fc);
      ttr_pkg::req_item_type it;
      it.req_type    = op;
      it.table_index = idx;
      it.write_value = val;
      it.frame_count = fc;
      return it;
   endfunction

   // Offer one item and hold it until the block takes it. Enter and leave on
   // a rising edge; keep push high across back-to-back items so it never gets
   // two assignments in one time step.
   task automatic send_item(ttr_pkg::req_item_type it);
      int unsigned gap;
      gap = back_to_back ? 0 : draw_wait(req_burst);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_texel(it);
      items_sent++;
   endtask

   // Render one pixel, first loading whatever entries it reads that are not
   // loaded yet (or all of them when refresh is set, right before the render,
   // to hit write-then-read hazards inside the pipeline).
   task automatic render_pixel(logic [15:0] c, logic [15:0] idx, bit refresh);
      logic [15:0] taddr;
      if (refresh || !sine_loaded[c[7:0]])
         send_item(make_item(ttr_pkg::OP_SINE_WR, {8'($urandom), c[7:0]},
                             16'($urandom), 16'($urandom)));
      if (refresh || !sine_loaded[{c[6:0], 1'b0}])
         send_item(make_item(ttr_pkg::OP_SINE_WR, {8'($urandom), c[6:0], 1'b0},
                             16'($urandom), 16'($urandom)));
      if (refresh || !map_loaded[map_slot(idx)])
         send_item(make_item(ttr_pkg::OP_MAP_WR, idx, 16'($urandom), 16'($urandom)));
      // the texel address depends on the entries just written
      taddr = texel_addr(c, idx);
      if (refresh || !tex_loaded[taddr])
         send_item(make_item(ttr_pkg::OP_TEX_WR, taddr, 16'($urandom), 16'($urandom)));
      send_item(make_item(ttr_pkg::OP_RENDER, idx, 16'($urandom), c));
   endtask

   // Corners: sine extremes written through wrapping addresses, texture bytes
   // with junk in the high data byte, map words at both ends, frame counts and
   // pixel indices at both ends, and a texel rewritten between two renders.
   task automatic test_directed_corners();
      logic [15:0] taddr;
      send_item(make_item(ttr_pkg::OP_SINE_WR, 16'hFF00, 16'h8000, 16'hFFFF));
      send_item(make_item(ttr_pkg::OP_SINE_WR, 16'h00FF, 16'h7FFF, 16'h0000));
      send_item(make_item(ttr_pkg::OP_SINE_WR, 16'hABFE, 16'hFFFF, 16'h5555));
      send_item(make_item(ttr_pkg::OP_SINE_WR, 16'h0080, 16'h0000, 16'hAAAA));
      send_item(make_item(ttr_pkg::OP_MAP_WR, 16'h0000, 16'hFFFF, 16'hFFFF));
      send_item(make_item(ttr_pkg::OP_MAP_WR, 16'hFFFF, 16'h0000, 16'h0000));
      send_item(make_item(ttr_pkg::OP_MAP_WR, 16'h8000, 16'h1234, 16'hFFFF));
      send_item(make_item(ttr_pkg::OP_TEX_WR, 16'h0000, 16'hFF00, 16'hFFFF));
      send_item(make_item(ttr_pkg::OP_TEX_WR, 16'hFFFF, 16'h00FF, 16'h0000));
      render_pixel(16'h0000, 16'h0000, 1'b0);
      render_pixel(16'hFFFF, 16'hFFFF, 1'b0);
      render_pixel(16'h0080, 16'h8000, 1'b0);
      render_pixel(16'h0000, 16'hFFFF, 1'b0);
      render_pixel(16'hFFFF, 16'h0000, 1'b0);
      // overwrite the texel the first pixel reads and render it again
      taddr = texel_addr(16'h0000, 16'h0000);
      send_item(make_item(ttr_pkg::OP_TEX_WR, taddr, 16'h00FF, 16'hFFFF));
      send_item(make_item(ttr_pkg::OP_RENDER, 16'h0000, 16'hFFFF, 16'h0000));
      send_item(make_item(ttr_pkg::OP_TEX_WR, taddr, 16'hFF00, 16'h0000));
      send_item(make_item(ttr_pkg::OP_RENDER, 16'h0000, 16'h0000, 16'h0000));
   endtask

   // Write every entry a render reads on the cycles just before it, with no
   // input gaps, so the pipeline must forward or order its table accesses.
   task automatic test_write_then_render();
      back_to_back = 1'b1;
      repeat (40) render_pixel(16'($urandom), 16'($urandom_range(0, 15)), 1'b1);
      back_to_back = 1'b0;
   endtask

   // Mostly well-formed load-and-render sequences with random content; a share
   // of stray writes that overwrite or scatter table entries.
   task automatic test_random_stream();
      int unsigned stop_at;
      int unsigned pick;
      logic [15:0] idx;
      stop_at = items_sent + RandomOps;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         // reuse a small set of pixels half the time so loaded entries get reread
         idx  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
         if (pick < 20)
            send_item(make_item(ttr_pkg::op_type'($urandom_range(0, 2)), 16'($urandom),
                                16'($urandom), 16'($urandom)));
         else
            render_pixel(16'($urandom), idx, pick < 35);
      end
   endtask

   // Result side: stall a random number of cycles, then pop one item and check
   // it against the oldest pending pixel.
   initial begin : pixel_checker
      ttr_pkg::rsp_item_type px;
      int unsigned           stall;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_burst);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         if (pixel_expect_q.size() == 0) begin
            $display("%0t: unexpected item: pixel_index %h pixel_value %h",
                     $time, rsp_data.pixel_index, rsp_data.pixel_value);
            mismatch_count++;
         end else begin
            px = pixel_expect_q.pop_front();
            if (rsp_data.pixel_value !== px.pixel_value) begin
               $display("%0t: pixel_value expected %h actual %h (pixel_index %h)",
                        $time, px.pixel_value, rsp_data.pixel_value, px.pixel_index);
               mismatch_count++;
            end
            if (rsp_data.pixel_index !== px.pixel_index) begin
               $display("%0t: pixel_index expected %h actual %h",
                        $time, px.pixel_index, rsp_data.pixel_index);
               mismatch_count++;
            end
         end
      end
   end

   // Sequence: hold reset, run the tests in turn, drain the
   // pending pixels, let the pipeline settle, then report.
   initial begin : test_sequence
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_write_then_render();
      test_random_stream();
      req_push <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      // watch for stray items after the last expected one
      repeat (DrainWait) @(posedge clock);
      if (mismatch_count == 0 && pixel_expect_q.size() == 0)
         $display("tunnel_texture_renderer_top regression: pass");
      else
         $display("tunnel_texture_renderer_top regression: fail");
      $finish;
   end

endmodule

[filelist.f]
sv/ttr_pkg.sv
sv/ttr_ram.sv
sv/ttr_front.sv
sv/ttr_queue.sv
sv/ttr_back.sv
sv/tunnel_texture_renderer_top.sv
tb/sv/testbench.sv
